### sv/fbct_pkg.sv
// Shared types and constants of the FIFO block cache tag store.
package fbct_pkg;

    // Fixed field widths of the stream payloads.
    localparam int FILE_PORT_W    = 8;
    localparam int BLOCK_W        = 18;
    localparam int CLUSTER_PORT_W = 32;
    localparam int SLOT_W         = 8;
    localparam int DROP_W         = 9;
    localparam int S_TDATA_W      = 80;
    localparam int M_TDATA_W      = 56;

    // Request kinds carried in s_tuser.
    typedef enum logic [1:0] {
        MODE_READ   = 2'd0,
        MODE_WRITE  = 2'd1,
        MODE_DROP   = 2'd2,
        MODE_IGNORE = 2'd3
    } mode_t;

    // Compare outcome for one tag entry against the current request.
    typedef struct packed {
        logic access_hit;
        logic drop_hit;
    } fbct_match_t;

endpackage

### sv/fbct_match.sv
// Tag comparator: checks one stored entry against a lookup or a drop range.
module fbct_match
    import fbct_pkg::*;
#(
    parameter int FILE_ID_BITS = 8
) (
    input  logic                        entry_valid,
    input  logic [FILE_ID_BITS-1:0]     entry_file,
    input  logic [BLOCK_W-1:0]          entry_block,
    input  logic [FILE_ID_BITS-1:0]     req_file,
    input  logic [BLOCK_W-1:0]          req_block,
    input  logic [BLOCK_W-1:0]          req_high,
    output fbct_match_t                 match
);

    logic same_file;

    // A valid entry of the same file is a candidate for both checks.
    assign same_file = entry_valid && (entry_file == req_file);

    // Exact block for lookups; half-open range (low, high] for drops.
    always_comb begin
        match.access_hit = same_file && (entry_block == req_block);
        match.drop_hit   = same_file && (entry_block > req_block) &&
                           (entry_block <= req_high);
    end

endmodule

### sv/fifo_block_cache_tags_core.sv
// Top level of the fully associative FIFO block cache tag store.
//
// Tag and control store of ENTRIES slots held in one synchronous RAM with
// registered read data. Each read, write or drop beat is handled by a linear
// scan that reads one entry per cycle through the single read port; a lookup
// ends the scan at its first hit. A mode-three beat is not scanned. A
// miss takes the slot under the round-robin pointer, which the same scan
// reads on the way, and reports a writeback when that victim is dirty. A
// drop request clears matching entries in place during the scan and counts
// them (saturating at 511). After reset a clearing pass writes every RAM
// entry once before the first request is taken. A finished result waits in
// the output register, so the next request beat can be taken before the
// previous result has been consumed.
module fifo_block_cache_tags_core
    import fbct_pkg::*;
#(
    parameter int ENTRIES      = 256,
    parameter int FILE_ID_BITS = 8,
    parameter int CLUSTER_BITS = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // s_tdata from bit 0: file_id[7:0], block_num[17:0], block_high[17:0],
    // cluster[31:0], four zero bits.
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // s_tuser: mode[1:0].
    input  logic [1:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // m_tdata from bit 0: hit, fill, slot[7:0], writeback,
    // writeback_cluster[31:0], dropped[8:0], four zero bits.
    output logic [M_TDATA_W-1:0]  m_tdata
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
    localparam logic [DROP_W-1:0] DROP_MAX = '1;

    typedef struct packed {
        logic                    valid;
        logic                    dirty;
        logic [FILE_ID_BITS-1:0] file;
        logic [BLOCK_W-1:0]      block;
        logic [CLUSTER_BITS-1:0] cluster;
    } entry_t;

    typedef enum logic [3:0] {
        ST_CLEAR  = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_SCAN   = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    // Tag RAM.
    entry_t mem [ENTRIES];

    state_t                  state_reg, state_next;
    logic [IDX_W-1:0]        clr_addr_reg, clr_addr_next;
    logic [IDX_W-1:0]        ptr_reg, ptr_next;
    logic [IDX_W-1:0]        raddr_reg, raddr_next;
    logic                    issue_done_reg, issue_done_next;
    logic                    chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0]        chk_addr_reg, chk_addr_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]    m_tdata_reg, m_tdata_next;

    mode_t                   mode_reg, mode_next;
    logic [FILE_ID_BITS-1:0] fid_reg, fid_next;
    logic [BLOCK_W-1:0]      blk_reg, blk_next;
    logic [BLOCK_W-1:0]      bhigh_reg, bhigh_next;
    logic [CLUSTER_BITS-1:0] clu_reg, clu_next;
    logic                    hit_reg, hit_next;
    logic [IDX_W-1:0]        slot_reg, slot_next;
    entry_t                  hit_word_reg, hit_word_next;
    entry_t                  victim_reg, victim_next;
    logic [DROP_W-1:0]       drop_cnt_reg, drop_cnt_next;
    entry_t                  rd_word_reg;

    logic                    mem_we;
    logic [IDX_W-1:0]        mem_waddr;
    entry_t                  mem_wdata;

    fbct_match_t             match;
    logic                    issue;
    logic                    is_access;
    logic                    is_drop;
    logic                    acc_hit_now;
    logic                    drop_hit_now;
    logic                    chk_last;
    logic                    out_free;
    logic                    fire;
    logic                    res_hit, res_fill, res_wb;
    logic [SLOT_W-1:0]       res_slot;
    logic [CLUSTER_PORT_W-1:0] res_wbc;
    logic [DROP_W-1:0]       res_dropped;
    entry_t                  new_word;
    entry_t                  dirty_word;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Compare the entry returned by the RAM against the held request.
    fbct_match #(
        .FILE_ID_BITS(FILE_ID_BITS)
    ) u_match (
        .entry_valid (rd_word_reg.valid),
        .entry_file  (rd_word_reg.file),
        .entry_block (rd_word_reg.block),
        .req_file    (fid_reg),
        .req_block   (blk_reg),
        .req_high    (bhigh_reg),
        .match       (match)
    );

    // Scan control terms.
    assign issue        = (state_reg == ST_SCAN) && !issue_done_reg;
    assign is_drop      = (mode_reg == MODE_DROP);
    assign is_access    = (mode_reg == MODE_READ) || (mode_reg == MODE_WRITE);
    assign acc_hit_now  = (state_reg == ST_SCAN) && chk_vld_reg && is_access &&
                          match.access_hit;
    assign drop_hit_now = (state_reg == ST_SCAN) && chk_vld_reg && is_drop &&
                          match.drop_hit;
    assign chk_last     = chk_vld_reg && (chk_addr_reg == LAST_IDX);
    assign out_free     = !m_tvalid_reg || m_tready;
    assign fire         = (state_reg == ST_FINISH) && out_free;

    // Words written back at the end of an access.
    always_comb begin
        new_word.valid   = 1'b1;
        new_word.dirty   = (mode_reg == MODE_WRITE);
        new_word.file    = fid_reg;
        new_word.block   = blk_reg;
        new_word.cluster = clu_reg;
        dirty_word       = hit_word_reg;
        dirty_word.dirty = 1'b1;
    end

    // Result fields of the finished request.
    always_comb begin
        res_hit     = is_access && hit_reg;
        res_fill    = is_access && !hit_reg;
        res_slot    = is_access ? SLOT_W'(slot_reg) : '0;
        res_wb      = res_fill && victim_reg.valid && victim_reg.dirty;
        res_wbc     = res_wb ? CLUSTER_PORT_W'(victim_reg.cluster) : '0;
        res_dropped = is_drop ? drop_cnt_reg : '0;
    end

    // RAM write port: clearing pass, in-place drop, or access update.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = chk_addr_reg;
        mem_wdata = '0;
        if (state_reg == ST_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
        end else if (drop_hit_now) begin
            mem_we    = 1'b1;
            mem_waddr = chk_addr_reg;
        end else if (fire && is_access) begin
            if (!hit_reg) begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg;
                mem_wdata = new_word;
            end else if (mode_reg == MODE_WRITE) begin
                mem_we    = 1'b1;
                mem_waddr = slot_reg;
                mem_wdata = dirty_word;
            end
        end
    end

    // RAM with registered read data.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_word_reg <= mem[raddr_reg];
    end

    // Sequencer next-state logic.
    always_comb begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        ptr_next        = ptr_reg;
        raddr_next      = raddr_reg;
        issue_done_next = issue_done_reg;
        chk_vld_next    = 1'b0;
        chk_addr_next   = raddr_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        mode_next       = mode_reg;
        fid_next        = fid_reg;
        blk_next        = blk_reg;
        bhigh_next      = bhigh_reg;
        clu_next        = clu_reg;
        hit_next        = hit_reg;
        slot_next       = slot_reg;
        hit_word_next   = hit_word_reg;
        victim_next     = victim_reg;
        drop_cnt_next   = drop_cnt_reg;

        // The consumer takes the pending result beat.
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == LAST_IDX) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    mode_next       = mode_t'(s_tuser);
                    fid_next        = FILE_ID_BITS'(s_tdata[FILE_PORT_W-1:0]);
                    blk_next        = s_tdata[25:8];
                    bhigh_next      = s_tdata[43:26];
                    clu_next        = CLUSTER_BITS'(s_tdata[75:44]);
                    hit_next        = 1'b0;
                    slot_next       = ptr_reg;
                    drop_cnt_next   = '0;
                    raddr_next      = '0;
                    issue_done_next = 1'b0;
                    if (mode_t'(s_tuser) == MODE_IGNORE) begin
                        state_next = ST_FINISH;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                // Issue the next read while the previous entry is checked.
                if (issue) begin
                    chk_vld_next  = 1'b1;
                    chk_addr_next = raddr_reg;
                    raddr_next    = raddr_reg + 1'b1;
                    if (raddr_reg == LAST_IDX) begin
                        issue_done_next = 1'b1;
                    end
                end
                // Keep the entry under the pointer as the miss victim.
                if (chk_vld_reg && (chk_addr_reg == ptr_reg)) begin
                    victim_next = rd_word_reg;
                end
                if (drop_hit_now && (drop_cnt_reg != DROP_MAX)) begin
                    drop_cnt_next = drop_cnt_reg + 1'b1;
                end
                if (acc_hit_now) begin
                    hit_next        = 1'b1;
                    slot_next       = chk_addr_reg;
                    hit_word_next   = rd_word_reg;
                    chk_vld_next    = 1'b0;
                    issue_done_next = 1'b1;
                    state_next      = ST_FINISH;
                end else if (chk_last) begin
                    chk_vld_next    = 1'b0;
                    issue_done_next = 1'b1;
                    state_next      = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {4'b0000, res_dropped, res_wbc, res_wb,
                                     res_slot, res_fill, res_hit};
                    if (is_access && !hit_reg) begin
                        ptr_next = (ptr_reg == LAST_IDX) ? '0 : ptr_reg + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '0;
            ptr_reg        <= '0;
            issue_done_reg <= 1'b1;
            chk_vld_reg    <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            ptr_reg        <= ptr_next;
            issue_done_reg <= issue_done_next;
            chk_vld_reg    <= chk_vld_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        raddr_reg    <= raddr_next;
        chk_addr_reg <= chk_addr_next;
        m_tdata_reg  <= m_tdata_next;
        mode_reg     <= mode_next;
        fid_reg      <= fid_next;
        blk_reg      <= blk_next;
        bhigh_reg    <= bhigh_next;
        clu_reg      <= clu_next;
        hit_reg      <= hit_next;
        slot_reg     <= slot_next;
        hit_word_reg <= hit_word_next;
        victim_reg   <= victim_next;
        drop_cnt_reg <= drop_cnt_next;
    end

endmodule

### tb/fifo_block_cache_tags_core_test.sv
// Self-checking testbench for the FIFO block cache tag store core.
`timescale 1ns / 1ps

module fifo_block_cache_tags_core_test;
    import fbct_pkg::*;

    localparam int ENTRIES     = 256;
    localparam int CLK_HALF    = 10;
    localparam int RESET_CYCLES = 7;
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int MAX_GAP     = 300;
    localparam int HISTORY_MAX = 256;

    // One request beat as the stimulus sees it.
    typedef struct packed {
        mode_t       mode;
        logic [7:0]  file;
        logic [17:0] blk;
        logic [17:0] blk_high;
        logic [31:0] cluster;
    } cache_req_t;

    // One result beat, field by field.
    typedef struct packed {
        logic        hit;
        logic        fill;
        logic [7:0]  slot;
        logic        writeback;
        logic [31:0] wb_cluster;
        logic [8:0]  dropped;
    } cache_result_t;

    // Tag of a block that was installed, kept for later hits.
    typedef struct packed {
        logic [7:0]  file;
        logic [17:0] blk;
    } block_tag_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [1:0]           s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // Shadow copy of the tag store.
    logic        line_valid   [ENTRIES];
    logic        line_dirty   [ENTRIES];
    logic [7:0]  line_file    [ENTRIES];
    logic [17:0] line_block   [ENTRIES];
    logic [31:0] line_cluster [ENTRIES];
    logic [7:0]  fill_ptr;

    cache_result_t pending_results[$];
    block_tag_t    installed_tags[$];
    cache_result_t got_result;
    cache_result_t want_result;

    int tx_idle_pct = 23;
    int rx_idle_pct = 86;
    int error_count = 0;
    int cycle_count = 0;
    int n_requests  = 0;
    int n_hits      = 0;
    int n_fills     = 0;
    int n_evictions = 0;
    int n_drops     = 0;
    int n_removed   = 0;
    int n_ignored   = 0;

    fifo_block_cache_tags_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     pending_results.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // The receiver stalls at random, changing tready on the falling edge.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    function automatic cache_req_t make_req(mode_t mode, logic [7:0] file,
                                            logic [17:0] blk, logic [17:0] blk_high,
                                            logic [31:0] cluster);
        cache_req_t req;
        req.mode     = mode;
        req.file     = file;
        req.blk      = blk;
        req.blk_high = blk_high;
        req.cluster  = cluster;
        return req;
    endfunction

    // Computes the result of one request and updates the shadow tag store.
    function automatic cache_result_t predict_lookup(cache_req_t req);
        cache_result_t res;
        int            count;
        bit            found;
        res   = '0;
        count = 0;
        found = 0;
        n_requests++;
        case (req.mode)
            MODE_DROP: begin
                for (int k = 0; k < ENTRIES; k++) begin
                    if (line_valid[k] && line_file[k] == req.file &&
                        line_block[k] > req.blk && line_block[k] <= req.blk_high) begin
                        line_valid[k] = 1'b0;
                        line_dirty[k] = 1'b0;
                        count++;
                    end
                end
                res.dropped = (count > 511) ? 9'd511 : 9'(count);
                n_drops++;
                n_removed += count;
            end
            MODE_IGNORE: begin
                n_ignored++;
            end
            default: begin
                // Lowest matching slot wins.
                for (int k = 0; k < ENTRIES && !found; k++) begin
                    if (line_valid[k] && line_file[k] == req.file &&
                        line_block[k] == req.blk) begin
                        found = 1;
                        if (req.mode == MODE_WRITE)
                            line_dirty[k] = 1'b1;
                        res.hit  = 1'b1;
                        res.slot = 8'(k);
                    end
                end
                if (found) begin
                    n_hits++;
                end else begin
                    // Miss: evict the slot under the pointer, writing it back if dirty.
                    if (line_valid[fill_ptr] && line_dirty[fill_ptr]) begin
                        res.writeback  = 1'b1;
                        res.wb_cluster = line_cluster[fill_ptr];
                        n_evictions++;
                    end
                    line_valid[fill_ptr]   = 1'b1;
                    line_dirty[fill_ptr]   = (req.mode == MODE_WRITE);
                    line_file[fill_ptr]    = req.file;
                    line_block[fill_ptr]   = req.blk;
                    line_cluster[fill_ptr] = req.cluster;
                    res.fill = 1'b1;
                    res.slot = fill_ptr;
                    fill_ptr = fill_ptr + 8'd1;
                    n_fills++;
                end
            end
        endcase
        return res;
    endfunction

    // Sends one request beat, with an optional random gap first. Starts and
    // ends on a falling edge.
    task automatic send_request(input cache_req_t req);
        int gap;
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            gap = $urandom_range(1, MAX_GAP);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req.mode;
        s_tdata  <= {4'b0, req.cluster, req.blk_high, req.blk, req.file};
        do @(posedge aclk); while (!s_tready);
        pending_results.insert(pending_results.size(), predict_lookup(req));
        @(negedge aclk);
    endtask

    // Holds the input off until every outstanding result has come back.
    task automatic pause_until_drained();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending_results.size() != 0);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            error_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    // Compares each result beat with the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_result.hit        = m_tdata[0];
            got_result.fill       = m_tdata[1];
            got_result.slot       = m_tdata[9:2];
            got_result.writeback  = m_tdata[10];
            got_result.wb_cluster = m_tdata[42:11];
            got_result.dropped    = m_tdata[51:43];
            if (pending_results.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result beat, expected none, actual %h",
                         $time, m_tdata);
            end else begin
                want_result = pending_results.pop_front();
                check_field("hit", 32'(want_result.hit), 32'(got_result.hit));
                check_field("fill", 32'(want_result.fill), 32'(got_result.fill));
                check_field("slot", 32'(want_result.slot), 32'(got_result.slot));
                check_field("writeback", 32'(want_result.writeback),
                            32'(got_result.writeback));
                check_field("writeback_cluster", want_result.wb_cluster,
                            got_result.wb_cluster);
                check_field("dropped", 32'(want_result.dropped), 32'(got_result.dropped));
                check_field("padding", 32'd0, 32'(m_tdata[55:52]));
            end
        end
    end

    // Hits, write hits, misses at the field extremes and the ignored mode.
    task automatic test_basic_access();
        send_request(make_req(MODE_READ, 8'd0, 18'd0, 18'd0, 32'd0));
        send_request(make_req(MODE_WRITE, 8'hFF, 18'h3FFFF, 18'h3FFFF, 32'hFFFF_FFFF));
        send_request(make_req(MODE_READ, 8'd0, 18'd0, 18'h3FFFF, 32'hFFFF_FFFF));
        send_request(make_req(MODE_WRITE, 8'd0, 18'd0, 18'd0, 32'h0000_1234));
        // Same block number under another file is a different block.
        send_request(make_req(MODE_READ, 8'hFF, 18'd0, 18'd7, 32'hA5A5_5A5A));
        send_request(make_req(MODE_WRITE, 8'hAA, 18'h15555, 18'h2AAAA, 32'h5555_AAAA));
        send_request(make_req(MODE_IGNORE, 8'hFF, 18'h3FFFF, 18'h3FFFF, 32'hFFFF_FFFF));
        send_request(make_req(MODE_READ, 8'hFF, 18'h3FFFF, 18'd0, 32'd1));
        send_request(make_req(MODE_READ, 8'h55, 18'h2AAAA, 18'h15555, 32'hAAAA_5555));
    endtask

    // Drop ranges: empty, inverted, both bounds and a refill after a drop.
    task automatic test_drop_ranges();
        send_request(make_req(MODE_DROP, 8'd0, 18'd0, 18'd0, 32'd0));
        send_request(make_req(MODE_DROP, 8'hFF, 18'd10, 18'd5, 32'd0));
        send_request(make_req(MODE_DROP, 8'hFF, 18'd0, 18'h3FFFF, 32'hFFFF_FFFF));
        // The lower bound is exclusive, so block zero stays.
        send_request(make_req(MODE_DROP, 8'd0, 18'd0, 18'h3FFFF, 32'd0));
        // The upper bound is inclusive.
        send_request(make_req(MODE_DROP, 8'hAA, 18'h15554, 18'h15555, 32'd0));
        send_request(make_req(MODE_READ, 8'hFF, 18'h3FFFF, 18'd0, 32'h0BAD_CAFE));
        send_request(make_req(MODE_DROP, 8'hFF, 18'h3FFFF, 18'h3FFFF, 32'd0));
        send_request(make_req(MODE_DROP, 8'hFF, 18'h3FFFE, 18'h3FFFF, 32'd0));
        send_request(make_req(MODE_READ, 8'hFF, 18'd0, 18'd0, 32'd2));
    endtask

    // Mixed traffic: mostly fresh blocks to cycle the pointer round, reuse of
    // recent blocks for hits, drops over small ranges, and some noise.
    task automatic test_random_traffic(input int n_items, input int tx_pct, input int rx_pct);
        cache_req_t req;
        block_tag_t tag;
        int         sent;
        int         pick;
        sent = 0;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        while (sent < n_items) begin
            pick = $urandom_range(0, 99);
            req.mode     = ($urandom_range(0, 1) == 0) ? MODE_READ : MODE_WRITE;
            req.file     = ($urandom_range(0, 9) < 3) ? 8'($urandom) : 8'($urandom_range(1, 4));
            req.blk      = ($urandom_range(0, 3) == 0) ? 18'($urandom)
                                                       : 18'($urandom_range(0, 511));
            req.blk_high = 18'($urandom);
            req.cluster  = $urandom;
            if (pick < 52) begin
                tag.file = req.file;
                tag.blk  = req.blk;
                installed_tags.insert(installed_tags.size(), tag);
                if (installed_tags.size() > HISTORY_MAX)
                    void'(installed_tags.pop_front());
            end else if (pick < 78 && installed_tags.size() != 0) begin
                tag      = installed_tags[$urandom_range(0, installed_tags.size() - 1)];
                req.file = tag.file;
                req.blk  = tag.blk;
            end else if (pick < 90) begin
                req.mode = MODE_DROP;
                if (installed_tags.size() != 0 && $urandom_range(0, 1) == 0)
                    req.file = installed_tags[$urandom_range(0, installed_tags.size() - 1)].file;
                if ($urandom_range(0, 99) >= 15) begin
                    req.blk      = 18'($urandom_range(0, 511));
                    req.blk_high = req.blk + 18'($urandom_range(0, 96));
                end
            end else if (pick < 95) begin
                req.mode = MODE_IGNORE;
            end else begin
                req.mode = mode_t'($urandom_range(0, 3));
                req.file = 8'($urandom);
            end
            send_request(req);
            sent++;
        end
    endtask

    // Main sequence.
    initial begin
        for (int k = 0; k < ENTRIES; k++) begin
            line_valid[k]   = 1'b0;
            line_dirty[k]   = 1'b0;
            line_file[k]    = '0;
            line_block[k]   = '0;
            line_cluster[k] = '0;
        end
        fill_ptr = '0;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_basic_access();
        test_drop_ranges();
        pause_until_drained();
        test_random_traffic(160, 23, 86);
        pause_until_drained();
        test_random_traffic(150, 86, 23);
        pause_until_drained();
        test_random_traffic(140, 0, 0);

        // Let the last results drain, then allow one more scan for strays.
        pause_until_drained();
        repeat (ENTRIES + 20) @(negedge aclk);
        $display("Covered %0d requests: %0d hits, %0d fills, %0d dirty evictions.",
                 n_requests, n_hits, n_fills, n_evictions);
        $display("Issued %0d drops that removed %0d entries, plus %0d ignored requests.",
                 n_drops, n_removed, n_ignored);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
